[design/lhc_pkg.sv]
// ----------------------------------------------------------------------------
// lhc_pkg
// Shared sizes, codes and the latency bucket function of the histogram counter.
// ----------------------------------------------------------------------------
package lhc_pkg;

  localparam int NODES        = 4;
  localparam int BUCKETS      = 16;
  localparam int EVENT_KINDS  = 3;

  localparam int PAIR_DEPTH   = EVENT_KINDS * NODES * NODES;
  localparam int BUCKET_DEPTH = PAIR_DEPTH * BUCKETS;

  localparam int CNT_W        = 64;
  localparam int LAT_W        = 31;
  localparam int KIND_W       = 3;
  localparam int EV_W         = 2;
  localparam int NODE_W       = 2;
  localparam int BKT_W        = $clog2(BUCKETS);
  localparam int PAIR_AW      = $clog2(PAIR_DEPTH);
  localparam int BKT_AW       = $clog2(BUCKET_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_COUNT      = 3'd0,
    KIND_READ_BKT   = 3'd1,
    KIND_READ_PAIR  = 3'd2,
    KIND_READ_EVENT = 3'd3,
    KIND_READ_TOTAL = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC
  } state_e;

  // Captured request fields
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [EV_W-1:0]   ev;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [LAT_W-1:0]  lat;
  } req_t;

  // Floor log2 by a five step binary search, 0 and 1 map to bucket 0,
  // saturate at the last bucket.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [LAT_W-1:0] lat);
    logic [31:0] v;
    logic [4:0]  m;
    v = {1'b0, lat};
    m = 5'd0;
    if (|v[31:16]) begin
      m[4] = 1'b1;
      v    = v >> 16;
    end
    if (|v[15:8]) begin
      m[3] = 1'b1;
      v    = v >> 8;
    end
    if (|v[7:4]) begin
      m[2] = 1'b1;
      v    = v >> 4;
    end
    if (|v[3:2]) begin
      m[1] = 1'b1;
      v    = v >> 2;
    end
    if (v[1]) begin
      m[0] = 1'b1;
    end
    if (int'(m) >= BUCKETS) begin
      return BKT_W'(BUCKETS - 1);
    end
    return BKT_W'(m);
  endfunction

endpackage

[design/log2_latency_histogram_counter.sv]
// ----------------------------------------------------------------------------
// log2_latency_histogram_counter
// Log2 latency histogram with pair, event and grand total counters.
// ----------------------------------------------------------------------------
// Each request goes through capture, memory read (registered RAM read),
// then modify/write back; busy is high in LOOKUP and EXEC after acceptance.
// A read result strobes for one cycle, registered as the EXEC state ends.
// After reset a clearing pass zeroes the RAMs, one entry per cycle, over all
// BUCKET_DEPTH (768) bucket entries with busy high. The receiver cannot stall.
module log2_latency_histogram_counter
  import lhc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [EV_W-1:0]   event_type_i,
  input  logic [NODE_W-1:0] source_node_i,
  input  logic [NODE_W-1:0] target_node_i,
  input  logic [LAT_W-1:0]  latency_i,
  output logic              read_strobe_o,
  output logic [CNT_W-1:0]  read_value_o
);

  state_e state_q, state_d;
  req_t   req_q;

  logic [BKT_AW-1:0]  clr_q;
  logic [BKT_AW-1:0]  bkt_addr_q;
  logic [PAIR_AW-1:0] pair_addr_q;
  logic               ok_q;

  logic [CNT_W-1:0] event_totals_q [EVENT_KINDS];
  logic [CNT_W-1:0] grand_total_q;
  logic [CNT_W-1:0] read_value_q;
  logic             read_strobe_q;

  logic               accept;
  logic               ok;
  logic               ev_ok;
  logic [BKT_W-1:0]   bkt;
  logic [PAIR_AW-1:0] pair_addr;
  logic [BKT_AW-1:0]  bkt_addr;
  logic               do_count;

  logic               bkt_we, pair_we, rd_en;
  logic [BKT_AW-1:0]  bkt_waddr;
  logic [PAIR_AW-1:0] pair_waddr;
  logic [CNT_W-1:0]   bkt_wdata, pair_wdata;
  logic [CNT_W-1:0]   bkt_rdata, pair_rdata;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Decode the captured request
  assign ev_ok = (int'(req_q.ev) < EVENT_KINDS);
  assign ok    = ev_ok && (int'(req_q.src) < NODES) && (int'(req_q.dst) < NODES);
  assign bkt   = bucket_of(req_q.lat);
  assign pair_addr = PAIR_AW'((int'(req_q.ev) * NODES + int'(req_q.src)) * NODES
                              + int'(req_q.dst));
  assign bkt_addr  = BKT_AW'(int'(pair_addr) * BUCKETS + int'(bkt));
  assign do_count  = (state_q == ST_EXEC) && ok_q && (kind_e'(req_q.kind) == KIND_COUNT);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (int'(clr_q) == BUCKET_DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_d = ST_EXEC;
      ST_EXEC:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + BKT_AW'(1);
      end
    end
  end

  // Capture the request and the lookup addresses
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.kind <= kind_i;
      req_q.ev   <= event_type_i;
      req_q.src  <= source_node_i;
      req_q.dst  <= target_node_i;
      req_q.lat  <= latency_i;
    end
    if (state_q == ST_LOOKUP) begin
      bkt_addr_q  <= bkt_addr;
      pair_addr_q <= pair_addr;
      ok_q        <= ok;
    end
  end

  // RAM port muxing: clearing pass or write back of the incremented counts
  always_comb begin
    rd_en      = (state_q == ST_LOOKUP);
    bkt_we     = 1'b0;
    pair_we    = 1'b0;
    bkt_waddr  = bkt_addr_q;
    pair_waddr = pair_addr_q;
    bkt_wdata  = bkt_rdata + CNT_W'(1);
    pair_wdata = pair_rdata + CNT_W'(1);
    if (state_q == ST_CLEAR) begin
      bkt_we     = 1'b1;
      pair_we    = (int'(clr_q) < PAIR_DEPTH);
      bkt_waddr  = clr_q;
      pair_waddr = clr_q[PAIR_AW-1:0];
      bkt_wdata  = '0;
      pair_wdata = '0;
    end else if (do_count) begin
      bkt_we  = 1'b1;
      pair_we = 1'b1;
    end
  end

  lhc_ram #(
    .DEPTH (BUCKET_DEPTH),
    .WIDTH (CNT_W)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_waddr),
    .wdata_i (bkt_wdata),
    .re_i    (rd_en),
    .raddr_i (bkt_addr),
    .rdata_o (bkt_rdata)
  );

  lhc_ram #(
    .DEPTH (PAIR_DEPTH),
    .WIDTH (CNT_W)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (pair_we),
    .waddr_i (pair_waddr),
    .wdata_i (pair_wdata),
    .re_i    (rd_en),
    .raddr_i (pair_addr),
    .rdata_o (pair_rdata)
  );

  // Advance the event and grand totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EVENT_KINDS; i++) begin
        event_totals_q[i] <= '0;
      end
      grand_total_q <= '0;
    end else if (do_count) begin
      event_totals_q[req_q.ev] <= event_totals_q[req_q.ev] + CNT_W'(1);
      grand_total_q            <= grand_total_q + CNT_W'(1);
    end
  end

  // Select and strobe the read result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_strobe_q <= 1'b0;
    end else begin
      read_strobe_q <= 1'b0;
      if (state_q == ST_EXEC) begin
        unique case (kind_e'(req_q.kind))
          KIND_READ_BKT,
          KIND_READ_PAIR,
          KIND_READ_EVENT,
          KIND_READ_TOTAL: read_strobe_q <= 1'b1;
          default:         read_strobe_q <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      unique case (kind_e'(req_q.kind))
        KIND_READ_BKT:   read_value_q <= ok_q ? bkt_rdata : '0;
        KIND_READ_PAIR:  read_value_q <= ok_q ? pair_rdata : '0;
        KIND_READ_EVENT: read_value_q <= ev_ok ? event_totals_q[req_q.ev] : '0;
        KIND_READ_TOTAL: read_value_q <= grand_total_q;
        default:         read_value_q <= read_value_q;
      endcase
    end
  end

  assign read_strobe_o = read_strobe_q;
  assign read_value_o  = read_value_q;

`ifndef ASSERT_OFF
  // An accepted request always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  // A result strobe follows the execute cycle
  a_strobe_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_strobe_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without an execute cycle");

  // No results during the clearing pass
  a_no_strobe_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !read_strobe_o)
    else $error("result strobe during clearing pass");

  // The grand total moves only on an executed count
  a_total_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(grand_total_q) |-> $past(state_q == ST_EXEC))
    else $error("grand total changed outside an execute cycle");
`endif

endmodule

[design/lhc_ram.sv]
// ----------------------------------------------------------------------------
// lhc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lhc_ram #(
  parameter int DEPTH = 48,
  parameter int WIDTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[test/tb_log2_latency_histogram_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log2_latency_histogram_counter
// Self-checking bench for the log2 latency histogram counter. A short table
// of directed requests covers reset contents, bucket edges, saturation, bad
// event types and spare kinds. A long random run follows, checked against a
// local model of the counters.
// ----------------------------------------------------------------------------
module tb_log2_latency_histogram_counter;
  import lhc_pkg::*;

  // Codes not covered by the package
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
  localparam logic [EV_W-1:0]   EV_TRY     = 2'd0;
  localparam logic [EV_W-1:0]   EV_SUCCESS = 2'd1;
  localparam logic [EV_W-1:0]   EV_FAIL    = 2'd2;
  localparam logic [EV_W-1:0]   EV_BAD     = 2'd3;

  localparam logic [LAT_W-1:0]  LAT_MAX    = {LAT_W{1'b1}};
  localparam int RANDOM_REQUESTS = 750;
  localparam int DRAIN_CYCLES    = 8;
  localparam int DIRECTED_ROWS   = 23;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              start         = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] kind_i        = '0;
  logic [EV_W-1:0]   event_type_i  = '0;
  logic [NODE_W-1:0] source_node_i = '0;
  logic [NODE_W-1:0] target_node_i = '0;
  logic [LAT_W-1:0]  latency_i     = '0;
  logic              read_strobe_o;
  logic [CNT_W-1:0]  read_value_o;

  log2_latency_histogram_counter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .event_type_i  (event_type_i),
    .source_node_i (source_node_i),
    .target_node_i (target_node_i),
    .latency_i     (latency_i),
    .read_strobe_o (read_strobe_o),
    .read_value_o  (read_value_o)
  );

  always #10 clk_i = ~clk_i;

  // Local copy of the counters
  logic [CNT_W-1:0] bkt_count_m   [BUCKET_DEPTH];
  logic [CNT_W-1:0] pair_count_m  [PAIR_DEPTH];
  logic [CNT_W-1:0] event_count_m [EVENT_KINDS];
  logic [CNT_W-1:0] total_count_m;

  logic [CNT_W-1:0] expected_reads [$];

  int errors     = 0;
  int n_counts   = 0;
  int n_reads    = 0;
  int n_ignored  = 0;
  int n_checked  = 0;
  bit burst_mode = 1'b0;

  // One directed request, with an optional value known at a glance
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [EV_W-1:0]   ev;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [LAT_W-1:0]  lat;
    logic              fixed;
    logic [CNT_W-1:0]  value;
  } stim_row_t;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // counters read back as zero right after reset
    '{KIND_READ_TOTAL, EV_TRY,     2'd0, 2'd0, 31'd0,       1'b1, 64'd0},
    '{KIND_READ_BKT,   EV_TRY,     2'd0, 2'd0, 31'd0,       1'b1, 64'd0},
    '{KIND_READ_EVENT, EV_FAIL,    2'd0, 2'd0, 31'd0,       1'b1, 64'd0},
    '{KIND_READ_PAIR,  EV_BAD,     2'd3, 2'd3, 31'd0,       1'b1, 64'd0},
    // latencies 0 and 1 share the first bucket
    '{KIND_COUNT,      EV_TRY,     2'd0, 2'd0, 31'd0,       1'b0, 64'd0},
    '{KIND_COUNT,      EV_TRY,     2'd0, 2'd0, 31'd1,       1'b0, 64'd0},
    '{KIND_READ_BKT,   EV_TRY,     2'd0, 2'd0, 31'd1,       1'b0, 64'd0},
    // largest latency saturates at the last bucket
    '{KIND_COUNT,      EV_FAIL,    2'd3, 2'd3, LAT_MAX,     1'b0, 64'd0},
    '{KIND_COUNT,      EV_SUCCESS, 2'd1, 2'd2, 31'd2,       1'b0, 64'd0},
    '{KIND_COUNT,      EV_SUCCESS, 2'd2, 2'd1, 31'd32767,   1'b0, 64'd0},
    '{KIND_COUNT,      EV_SUCCESS, 2'd2, 2'd1, 31'd32768,   1'b0, 64'd0},
    '{KIND_COUNT,      EV_SUCCESS, 2'd2, 2'd1, 31'd65536,   1'b0, 64'd0},
    '{KIND_READ_BKT,   EV_SUCCESS, 2'd2, 2'd1, 31'd40000,   1'b0, 64'd0},
    '{KIND_READ_BKT,   EV_FAIL,    2'd3, 2'd3, 31'h40000000, 1'b0, 64'd0},
    // bad event type changes nothing
    '{KIND_COUNT,      EV_BAD,     2'd0, 2'd0, 31'd5,       1'b0, 64'd0},
    // spare kinds are dropped without a result
    '{KIND_SPARE_FIRST, EV_TRY,    2'd1, 2'd1, LAT_MAX,     1'b0, 64'd0},
    '{KIND_SPARE_MID,  EV_FAIL,    2'd2, 2'd2, 31'd0,       1'b0, 64'd0},
    '{KIND_SPARE_LAST, EV_BAD,     2'd3, 2'd3, LAT_MAX,     1'b0, 64'd0},
    '{KIND_READ_PAIR,  EV_SUCCESS, 2'd2, 2'd1, 31'd0,       1'b0, 64'd0},
    '{KIND_READ_EVENT, EV_SUCCESS, 2'd0, 2'd0, 31'd0,       1'b0, 64'd0},
    '{KIND_READ_EVENT, EV_BAD,     2'd0, 2'd0, 31'd0,       1'b1, 64'd0},
    '{KIND_READ_BKT,   EV_BAD,     2'd1, 2'd1, 31'd7,       1'b1, 64'd0},
    '{KIND_READ_TOTAL, EV_TRY,     2'd0, 2'd0, 31'd0,       1'b0, 64'd0}
  };

  // Floor log2 of the latency, clamped to the last bucket
  function automatic int log2_bucket(input logic [LAT_W-1:0] lat);
    logic [LAT_W-1:0] v;
    int               b;
    v = lat;
    b = 0;
    while (v > 1) begin
      v = v >> 1;
      b++;
    end
    if (b >= BUCKETS) begin
      b = BUCKETS - 1;
    end
    return b;
  endfunction

  // Advance the counter model by one request and return its read value
  task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [EV_W-1:0] ev,
                               input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst,
                               input logic [LAT_W-1:0] lat, output bit has_read,
                               output logic [CNT_W-1:0] value);
    bit valid_pair;
    int pair;
    int bkt;
    valid_pair = (int'(ev) < EVENT_KINDS) && (int'(src) < NODES) && (int'(dst) < NODES);
    pair       = (int'(ev) * NODES + int'(src)) * NODES + int'(dst);
    bkt        = log2_bucket(lat);
    has_read   = 1'b1;
    value      = '0;
    case (kind)
      KIND_COUNT: begin
        has_read = 1'b0;
        if (valid_pair) begin
          bkt_count_m[pair * BUCKETS + bkt] += 1;
          pair_count_m[pair]                += 1;
          event_count_m[ev]                 += 1;
          total_count_m                     += 1;
        end
      end
      KIND_READ_BKT: begin
        if (valid_pair) value = bkt_count_m[pair * BUCKETS + bkt];
      end
      KIND_READ_PAIR: begin
        if (valid_pair) value = pair_count_m[pair];
      end
      KIND_READ_EVENT: begin
        if (int'(ev) < EVENT_KINDS) value = event_count_m[ev];
      end
      KIND_READ_TOTAL: begin
        value = total_count_m;
      end
      default: begin
        has_read = 1'b0;
      end
    endcase
  endtask

  // Present one request, hold it until accepted, then predict its result
  task automatic issue_request(input logic [KIND_W-1:0] kind, input logic [EV_W-1:0] ev,
                               input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst,
                               input logic [LAT_W-1:0] lat, input logic fixed,
                               input logic [CNT_W-1:0] fixed_value);
    bit               has_read;
    logic [CNT_W-1:0] value;
    start         <= 1'b1;
    kind_i        <= kind;
    event_type_i  <= ev;
    source_node_i <= src;
    target_node_i <= dst;
    latency_i     <= lat;
    do @(posedge clk_i); while (busy);
    apply_request(kind, ev, src, dst, lat, has_read, value);
    if (has_read) begin
      expected_reads.push_back(fixed ? fixed_value : value);
      n_reads++;
    end else if (kind == KIND_COUNT) begin
      n_counts++;
    end else begin
      n_ignored++;
    end
  endtask

  // Drop start for a random number of cycles, mostly short
  task automatic idle_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) gap = 0;
    else if (r < 90)          gap = $urandom_range(1, 3);
    else                      gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Latency with a random bit length so every bucket gets hit
  function automatic logic [LAT_W-1:0] random_latency();
    int               len;
    logic [LAT_W-1:0] lat;
    len = $urandom_range(0, LAT_W);
    lat = LAT_W'($urandom);
    if (len == 0) return '0;
    lat = lat & LAT_W'((64'd1 << len) - 1);
    return lat | LAT_W'(64'd1 << (len - 1));
  endfunction

  // Check each read result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && read_strobe_o) begin
      if (expected_reads.size() == 0) begin
        $error("read_value: unexpected result %h", read_value_o);
        errors++;
      end else begin
        if (read_value_o !== expected_reads[0]) begin
          $error("read_value: expected %h, actual %h", expected_reads[0], read_value_o);
          errors++;
        end
        void'(expected_reads.pop_front());
        n_checked++;
      end
    end
  end

  // Stimulus
  initial begin
    logic [KIND_W-1:0] kind;
    logic [EV_W-1:0]   ev;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    int                r;
    int                useful;
    int                wait_cycles;

    total_count_m = '0;
    foreach (bkt_count_m[i])   bkt_count_m[i]   = '0;
    foreach (pair_count_m[i])  pair_count_m[i]  = '0;
    foreach (event_count_m[i]) event_count_m[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].kind, directed_rows[i].ev, directed_rows[i].src,
                    directed_rows[i].dst, directed_rows[i].lat, directed_rows[i].fixed,
                    directed_rows[i].value);
      idle_gap();
    end

    // Random requests, counting only those the block acts on
    useful = 0;
    while (useful < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
      r = $urandom_range(0, 99);
      if (r < 5)       kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      else if (r < 60) kind = KIND_COUNT;
      else             kind = KIND_W'($urandom_range(KIND_READ_BKT, KIND_READ_TOTAL));
      ev  = ($urandom_range(0, 19) == 0) ? EV_BAD : EV_W'($urandom_range(EV_TRY, EV_FAIL));
      // concentrate traffic on a few node pairs so counters climb
      src = ($urandom_range(0, 9) < 7) ? NODE_W'($urandom_range(0, 1))
                                       : NODE_W'($urandom_range(0, NODES - 1));
      dst = ($urandom_range(0, 9) < 7) ? NODE_W'($urandom_range(0, 1))
                                       : NODE_W'($urandom_range(0, NODES - 1));
      issue_request(kind, ev, src, dst, random_latency(), 1'b0, '0);
      if (kind <= KIND_READ_TOTAL) useful++;
      idle_gap();
    end
    start <= 1'b0;

    // Drain outstanding results
    wait_cycles = 0;
    while (expected_reads.size() != 0 && wait_cycles < 200) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_reads.size() != 0) begin
      $error("read_value: %0d results never arrived", expected_reads.size());
      errors++;
    end

    $display("Covered %0d count and %0d read requests, %0d spare kinds dropped;",
             n_counts, n_reads, n_ignored);
    $display("%0d read results checked, %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop if the handshake hangs
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
